// File: rtl/lpfc_pkg.sv
// shared types and codes for the link path failover controller
// no dependencies; imported by link_path_failover_controller_unit
package lpfc_pkg;

  localparam int CountWidth = 8;
  localparam int CfgIndexWidth = 2;

  typedef logic [CountWidth-1:0] count_t;

  typedef enum logic [1:0] {
    PATH_DIRECT    = 2'd0,
    PATH_DISCOVERY = 2'd1,
    PATH_RELAY     = 2'd2
  } path_t;

  typedef enum logic [1:0] {
    ACT_DIRECT_RESULT = 2'd0,
    ACT_RELAY_READY   = 2'd1,
    ACT_RELAY_RESULT  = 2'd2,
    ACT_RECOVERY      = 2'd3
  } action_t;

  typedef enum logic {
    STATUS_ACCEPTED = 1'b0,
    STATUS_REJECTED = 1'b1
  } status_t;

  typedef enum logic [CfgIndexWidth-1:0] {
    REG_DIRECT_FAIL_LIMIT = 2'd0,
    REG_RECOVERY_LIMIT    = 2'd1,
    REG_RELAY_FAIL_LIMIT  = 2'd2,
    REG_UNUSED            = 2'd3
  } cfg_index_t;

  localparam count_t LimitReset = count_t'(3);
  localparam count_t CountMax   = '1;

  typedef struct packed {
    logic [1:0] action;
    logic       success;
  } in_item_t;

  typedef struct packed {
    logic       status;
    logic [1:0] path_state;
  } out_item_t;

endpackage

// File: rtl/link_path_failover_controller_unit.sv
// link path failover controller: direct / discovery / relay-active selector
// depends on lpfc_pkg for payload structs, path and action codes
//
//  channel  | handshake             | payload
//  ---------+-----------------------+-------------------------------
//  in       | in_valid / in_ready   | in_data  (action, success)
//  out      | out_valid / out_ready | out_data (status, path_state)
//  cfg      | cfg_valid / cfg_ready | cfg_index, cfg_data (8 bits)
//
// one event per cycle while in_ready is high; its result is registered into the
// output register, or into the skid entry while the output register still waits.
// a two-entry result buffer (output register plus skid) lets a new event
// enter while a result still waits; in_ready drops only when both are full.
// synchronous reset restores direct path, zero counters and limits of 3.
// cfg_ready is always high; writes to an unused index are dropped.
module link_path_failover_controller_unit (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_ready,
  input  lpfc_pkg::in_item_t  in_data,
  output logic              out_valid,
  input  logic              out_ready,
  output lpfc_pkg::out_item_t out_data,
  input  logic              cfg_valid,
  output logic              cfg_ready,
  input  logic [lpfc_pkg::CfgIndexWidth-1:0] cfg_index,
  input  logic [lpfc_pkg::CountWidth-1:0]    cfg_data
);
  import lpfc_pkg::*;

  count_t direct_fail_limit;
  count_t recovery_limit;
  count_t relay_fail_limit;

  path_t  path_mode, path_mode_next;
  count_t direct_fail_count, direct_fail_count_next;
  count_t relay_fail_count, relay_fail_count_next;
  count_t recovery_count, recovery_count_next;
  status_t status_next;

  out_item_t skid_data;
  logic      skid_valid;

  logic   in_take, out_take, limits_ok;
  count_t direct_inc, relay_inc, recovery_inc;

  assign cfg_ready = 1'b1;
  assign in_ready  = !skid_valid;
  assign in_take   = in_valid && in_ready;
  assign out_take  = out_valid && out_ready;

  assign limits_ok = (direct_fail_limit != '0) && (recovery_limit != '0) &&
                     (relay_fail_limit != '0);

  assign direct_inc   = (direct_fail_count == CountMax) ? CountMax
                        : direct_fail_count + count_t'(1);
  assign relay_inc    = (relay_fail_count == CountMax) ? CountMax
                        : relay_fail_count + count_t'(1);
  assign recovery_inc = (recovery_count == CountMax) ? CountMax
                        : recovery_count + count_t'(1);

  always_comb begin
    path_mode_next         = path_mode;
    direct_fail_count_next = direct_fail_count;
    relay_fail_count_next  = relay_fail_count;
    recovery_count_next    = recovery_count;
    status_next            = STATUS_REJECTED;
    if (limits_ok) begin
      case (action_t'(in_data.action))
        ACT_DIRECT_RESULT: begin
          if (path_mode == PATH_DIRECT) begin
            status_next = STATUS_ACCEPTED;
            if (in_data.success) begin
              direct_fail_count_next = '0;
            end else if (direct_inc >= direct_fail_limit) begin
              path_mode_next         = PATH_DISCOVERY;
              direct_fail_count_next = '0;
            end else begin
              direct_fail_count_next = direct_inc;
            end
          end
        end
        ACT_RELAY_READY: begin
          if (path_mode == PATH_DISCOVERY) begin
            status_next = STATUS_ACCEPTED;
            if (in_data.success) begin
              path_mode_next        = PATH_RELAY;
              relay_fail_count_next = '0;
              recovery_count_next   = '0;
            end
          end
        end
        ACT_RELAY_RESULT: begin
          if (path_mode == PATH_RELAY) begin
            status_next = STATUS_ACCEPTED;
            if (in_data.success) begin
              relay_fail_count_next = '0;
            end else if (relay_inc >= relay_fail_limit) begin
              path_mode_next        = PATH_DISCOVERY;
              relay_fail_count_next = '0;
              recovery_count_next   = '0;
            end else begin
              relay_fail_count_next = relay_inc;
            end
          end
        end
        default: begin
          if (path_mode == PATH_RELAY || path_mode == PATH_DISCOVERY) begin
            status_next = STATUS_ACCEPTED;
            if (!in_data.success) begin
              recovery_count_next = '0;
            end else if (recovery_inc >= recovery_limit) begin
              path_mode_next        = PATH_DIRECT;
              recovery_count_next   = '0;
              relay_fail_count_next = '0;
            end else begin
              recovery_count_next = recovery_inc;
            end
          end
        end
      endcase
    end
  end

  // limit registers
  always_ff @(posedge clk) begin
    if (rst) begin
      direct_fail_limit <= LimitReset;
      recovery_limit    <= LimitReset;
      relay_fail_limit  <= LimitReset;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index_t'(cfg_index))
        REG_DIRECT_FAIL_LIMIT: direct_fail_limit <= cfg_data;
        REG_RECOVERY_LIMIT:    recovery_limit    <= cfg_data;
        REG_RELAY_FAIL_LIMIT:  relay_fail_limit  <= cfg_data;
        default: ;
      endcase
    end
  end

  // path state and counters
  always_ff @(posedge clk) begin
    if (rst) begin
      path_mode         <= PATH_DIRECT;
      direct_fail_count <= '0;
      relay_fail_count  <= '0;
      recovery_count    <= '0;
    end else if (in_take) begin
      path_mode         <= path_mode_next;
      direct_fail_count <= direct_fail_count_next;
      relay_fail_count  <= relay_fail_count_next;
      recovery_count    <= recovery_count_next;
    end
  end

  // result buffer: output register with a skid entry behind it
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      skid_valid <= 1'b0;
    end else begin
      if (skid_valid) begin
        if (out_take) begin
          out_valid  <= 1'b1;
          skid_valid <= 1'b0;
        end
      end else if (in_take) begin
        if (out_valid && !out_take) begin
          skid_valid <= 1'b1;
        end else begin
          out_valid <= 1'b1;
        end
      end else if (out_take) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (skid_valid) begin
      if (out_take) begin
        out_data <= skid_data;
      end
    end else if (in_take) begin
      if (out_valid && !out_take) begin
        skid_data.status     <= status_next;
        skid_data.path_state <= path_mode_next;
      end else begin
        out_data.status     <= status_next;
        out_data.path_state <= path_mode_next;
      end
    end
  end

endmodule

// File: tb/link_path_failover_controller_unit_tb.sv
// self-checking testbench for link_path_failover_controller_unit
// drives events and limit writes, checks every result against an in-bench path predictor or a pinned expected value
// depends on lpfc_pkg and the rtl of the controller only
module link_path_failover_controller_unit_tb;
  import lpfc_pkg::*;

  // the cycle limit allows for the worst-case sender gap plus sink stall per event
  localparam int unsigned CycleLimit = 400_000;
  localparam int unsigned EventGoal = 1900;

  typedef struct packed {
    logic       is_write;
    cfg_index_t reg_idx;
    count_t     value;
    action_t    act;
    logic       ok;
    logic       pinned;
    out_item_t  want;
  } plan_row_t;

  logic       clk;
  logic       rst;
  logic       in_valid;
  logic       in_ready;
  in_item_t   in_data;
  logic       out_valid;
  logic       out_ready;
  out_item_t  out_data;
  logic       cfg_valid;
  logic       cfg_ready;
  logic [CfgIndexWidth-1:0] cfg_index;
  logic [CountWidth-1:0]    cfg_data;

  // path predictor state and its copy of the limits
  path_t  path_q;
  count_t dfail_cnt;
  count_t rfail_cnt;
  count_t recov_cnt;
  count_t dfail_lim;
  count_t recov_lim;
  count_t rfail_lim;

  out_item_t   results_due [$];
  plan_row_t   plan [$];
  logic        in_calm;
  logic        out_calm;
  int unsigned fails = 0;
  int unsigned checked = 0;
  int unsigned events_sent;
  int unsigned useful;
  int unsigned reg_writes;
  int unsigned cycle_count = 0;

  link_path_failover_controller_unit dut (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  function automatic count_t bump(count_t c);
    return (c == CountMax) ? c : c + 1'b1;
  endfunction

  // applies one event to the predicted path state and returns its result
  function automatic out_item_t route_event(in_item_t ev);
    out_item_t r;
    r.status = STATUS_REJECTED;
    if (dfail_lim != '0 && recov_lim != '0 && rfail_lim != '0) begin
      case (action_t'(ev.action))
        ACT_DIRECT_RESULT: if (path_q == PATH_DIRECT) begin
          r.status = STATUS_ACCEPTED;
          if (ev.success) begin
            dfail_cnt = '0;
          end else begin
            dfail_cnt = bump(dfail_cnt);
            if (dfail_cnt >= dfail_lim) begin
              path_q = PATH_DISCOVERY;
              dfail_cnt = '0;
            end
          end
        end
        ACT_RELAY_READY: if (path_q == PATH_DISCOVERY) begin
          r.status = STATUS_ACCEPTED;
          if (ev.success) begin
            path_q = PATH_RELAY;
            rfail_cnt = '0;
            recov_cnt = '0;
          end
        end
        ACT_RELAY_RESULT: if (path_q == PATH_RELAY) begin
          r.status = STATUS_ACCEPTED;
          if (ev.success) begin
            rfail_cnt = '0;
          end else begin
            rfail_cnt = bump(rfail_cnt);
            if (rfail_cnt >= rfail_lim) begin
              path_q = PATH_DISCOVERY;
              rfail_cnt = '0;
              recov_cnt = '0;
            end
          end
        end
        default: if (path_q == PATH_RELAY || path_q == PATH_DISCOVERY) begin
          r.status = STATUS_ACCEPTED;
          if (!ev.success) begin
            recov_cnt = '0;
          end else begin
            recov_cnt = bump(recov_cnt);
            if (recov_cnt >= recov_lim) begin
              path_q = PATH_DIRECT;
              recov_cnt = '0;
              rfail_cnt = '0;
            end
          end
        end
      endcase
    end
    r.path_state = path_q;
    return r;
  endfunction

  function automatic plan_row_t set_row(cfg_index_t r, count_t v);
    plan_row_t row;
    row = '0;
    row.is_write = 1'b1;
    row.reg_idx = r;
    row.value = v;
    return row;
  endfunction

  function automatic plan_row_t ev_row(action_t a, logic ok);
    plan_row_t row;
    row = '0;
    row.act = a;
    row.ok = ok;
    return row;
  endfunction

  function automatic plan_row_t pin_row(action_t a, logic ok, status_t st, path_t p);
    plan_row_t row;
    row = ev_row(a, ok);
    row.pinned = 1'b1;
    row.want.status = st;
    row.want.path_state = p;
    return row;
  endfunction

  // mostly small limits, now and then zero, the maximum or something large
  function automatic count_t draw_limit();
    int unsigned pick;
    pick = $urandom_range(0, 19);
    if (pick == 0) return '0;
    if (pick == 1) return CountMax;
    if (pick == 2) return count_t'($urandom_range(5, 254));
    return count_t'($urandom_range(1, 4));
  endfunction

  task automatic send_event(in_item_t ev, logic pinned, out_item_t want);
    int unsigned gap;
    out_item_t due;
    gap = in_calm ? 0 : $urandom_range(0, 7);
    cfg_valid <= 1'b0;
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data <= ev;
    do @(posedge clk); while (!in_ready);
    due = route_event(ev);
    if (due.status == STATUS_ACCEPTED) useful++;
    if (pinned) due = want;
    results_due = {results_due, due};
    events_sent++;
  endtask

  // leaves cfg_valid high so back-to-back writes go out with cfg_valid held high throughout
  task automatic write_limit(cfg_index_t r, count_t v);
    cfg_valid <= 1'b1;
    cfg_index <= r;
    cfg_data <= v;
    do @(posedge clk); while (!cfg_ready);
    case (r)
      REG_DIRECT_FAIL_LIMIT: dfail_lim = v;
      REG_RECOVERY_LIMIT:    recov_lim = v;
      REG_RELAY_FAIL_LIMIT:  rfail_lim = v;
      default: ;
    endcase
    reg_writes++;
  endtask

  // wait until every outstanding result is back, then let the pipeline settle
  task automatic settle();
    in_valid <= 1'b0;
    cfg_valid <= 1'b0;
    while (results_due.size() != 0) @(posedge clk);
    repeat (2) @(posedge clk);
  endtask

  initial begin : result_sink
    int unsigned hold;
    out_item_t want;
    out_ready <= 1'b1;
    forever begin
      @(posedge clk);
      if (!rst && out_valid && out_ready) begin
        if (results_due.size() == 0) begin
          $error("unexpected result: status %0d path_state %0d",
                 out_data.status, out_data.path_state);
          fails++;
        end else begin
          want = results_due.pop_front();
          if (out_data.status !== want.status) begin
            $error("status: expected %0d, got %0d", want.status, out_data.status);
            fails++;
          end
          if (out_data.path_state !== want.path_state) begin
            $error("path_state: expected %0d, got %0d", want.path_state,
                   out_data.path_state);
            fails++;
          end
          checked++;
        end
        hold = out_calm ? 0 : $urandom_range(0, 7);
        if (hold != 0) begin
          out_ready <= 1'b0;
          repeat (hold) @(posedge clk);
          out_ready <= 1'b1;
        end
      end
    end
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count == CycleLimit) begin
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  initial begin : stimulus
    in_item_t    stim;
    in_item_t    run_ev;
    path_t       run_path;
    int unsigned fail_pct;
    int unsigned phase_len;
    int unsigned sent_in_phase;
    int unsigned run_left;
    logic        zero_phase;

    rst <= 1'b1;
    in_valid <= 1'b0;
    in_data <= '0;
    cfg_valid <= 1'b0;
    cfg_index <= REG_DIRECT_FAIL_LIMIT;
    cfg_data <= '0;
    in_calm = 1'b0;
    out_calm = 1'b0;
    events_sent = 0;
    useful = 0;
    reg_writes = 0;
    path_q = PATH_DIRECT;
    dfail_cnt = '0;
    rfail_cnt = '0;
    recov_cnt = '0;
    dfail_lim = LimitReset;
    recov_lim = LimitReset;
    rfail_lim = LimitReset;

    plan = '{
      // one event of each action right after reset; all but the direct result are wrong-path
      pin_row(ACT_DIRECT_RESULT, 1'b1, STATUS_ACCEPTED, PATH_DIRECT),
      pin_row(ACT_RELAY_READY,   1'b1, STATUS_REJECTED, PATH_DIRECT),
      pin_row(ACT_RELAY_RESULT,  1'b0, STATUS_REJECTED, PATH_DIRECT),
      pin_row(ACT_RECOVERY,      1'b1, STATUS_REJECTED, PATH_DIRECT),
      ev_row(ACT_DIRECT_RESULT, 1'b0),
      ev_row(ACT_DIRECT_RESULT, 1'b0),
      // limit dropped under the running count: next failure moves the path
      set_row(REG_DIRECT_FAIL_LIMIT, 8'd1),
      pin_row(ACT_DIRECT_RESULT, 1'b0, STATUS_ACCEPTED, PATH_DISCOVERY),
      pin_row(ACT_DIRECT_RESULT, 1'b1, STATUS_REJECTED, PATH_DISCOVERY),
      ev_row(ACT_RELAY_READY, 1'b0),
      ev_row(ACT_RECOVERY, 1'b1),
      ev_row(ACT_RECOVERY, 1'b0),
      ev_row(ACT_RELAY_READY, 1'b1),
      ev_row(ACT_RELAY_RESULT, 1'b0),
      ev_row(ACT_RELAY_RESULT, 1'b1),
      set_row(REG_RELAY_FAIL_LIMIT, CountMax),
      set_row(REG_UNUSED, 8'd0),
      set_row(REG_RECOVERY_LIMIT, 8'd2),
      ev_row(ACT_RECOVERY, 1'b1),
      ev_row(ACT_RELAY_RESULT, 1'b0),
      ev_row(ACT_RECOVERY, 1'b1),
      // a zero limit blocks everything
      set_row(REG_RECOVERY_LIMIT, 8'd0),
      pin_row(ACT_DIRECT_RESULT, 1'b0, STATUS_REJECTED, PATH_DIRECT),
      pin_row(ACT_RECOVERY,      1'b1, STATUS_REJECTED, PATH_DIRECT),
      set_row(REG_RECOVERY_LIMIT, CountMax),
      set_row(REG_DIRECT_FAIL_LIMIT, CountMax),
      set_row(REG_RELAY_FAIL_LIMIT, 8'd1),
      ev_row(ACT_DIRECT_RESULT, 1'b0),
      ev_row(ACT_DIRECT_RESULT, 1'b1),
      set_row(REG_DIRECT_FAIL_LIMIT, 8'd1),
      pin_row(ACT_DIRECT_RESULT, 1'b0, STATUS_ACCEPTED, PATH_DISCOVERY),
      ev_row(ACT_RELAY_READY, 1'b1),
      pin_row(ACT_RELAY_RESULT, 1'b0, STATUS_ACCEPTED, PATH_DISCOVERY),
      ev_row(ACT_RECOVERY, 1'b1)
    };

    repeat (5) @(posedge clk);
    rst <= 1'b0;

    foreach (plan[i]) begin
      if (plan[i].is_write) begin
        settle();
        write_limit(plan[i].reg_idx, plan[i].value);
      end else begin
        stim.action = plan[i].act;
        stim.success = plan[i].ok;
        send_event(stim, plan[i].pinned, plan[i].want);
      end
    end

    // random phases: new limits, then runs of legal events with some noise mixed in
    run_ev = '0;
    run_path = PATH_DIRECT;
    while (events_sent < EventGoal) begin
      settle();
      write_limit(REG_DIRECT_FAIL_LIMIT, draw_limit());
      write_limit(REG_RECOVERY_LIMIT, draw_limit());
      write_limit(REG_RELAY_FAIL_LIMIT, draw_limit());
      if ($urandom_range(0, 3) == 0) write_limit(REG_UNUSED, count_t'($urandom));
      in_calm = ($urandom_range(0, 3) == 0);
      out_calm = ($urandom_range(0, 3) == 0);
      case ($urandom_range(0, 2))
        0: fail_pct = 15;
        1: fail_pct = 50;
        default: fail_pct = 85;
      endcase
      zero_phase = (dfail_lim == '0 || recov_lim == '0 || rfail_lim == '0);
      phase_len = zero_phase ? 15 : $urandom_range(60, 140);
      run_left = 0;
      sent_in_phase = 0;
      while (sent_in_phase < phase_len || (run_left != 0 && !zero_phase)) begin
        if (run_left == 0 || run_path != path_q) begin
          run_path = path_q;
          case (path_q)
            PATH_DIRECT:    run_ev.action = ACT_DIRECT_RESULT;
            PATH_DISCOVERY: run_ev.action = $urandom_range(0, 1) ? ACT_RECOVERY : ACT_RELAY_READY;
            default:        run_ev.action = $urandom_range(0, 1) ? ACT_RECOVERY : ACT_RELAY_RESULT;
          endcase
          run_ev.success = ($urandom_range(0, 99) >= fail_pct);
          // long runs are what reach the large limits
          run_left = ($urandom_range(0, 9) == 0) ? $urandom_range(1, 260) : $urandom_range(1, 6);
        end
        if ($urandom_range(0, 99) < 10) begin
          send_event(in_item_t'($urandom_range(0, 7)), 1'b0, '0);
        end else begin
          send_event(run_ev, 1'b0, '0);
          run_left--;
        end
        sent_in_phase++;
      end
    end

    settle();
    $display("sent %0d events (%0d taken by the path logic) over %0d register writes",
             events_sent, useful, reg_writes);
    $display("compared %0d results, %0d field errors", checked, fails);
    if (fails == 0 && results_due.size() == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
